// ===== src/fmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Forms message tokenizer package
// Shared constants, token and queue entry types for the tokenizer blocks.
// ----------------------------------------------------------------------------
package fmt_pkg;

  // Deepest embedded message nesting that is accepted.
  localparam int MAX_NEST_DEPTH = 8;
  localparam int DEPTH_W = $clog2(MAX_NEST_DEPTH + 1);
  // Entries in the queue between parser and token output.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] MARK_BYTE = 8'hf0;

  typedef enum logic [3:0] {
    K_HDR    = 4'd0,
    K_PROP   = 4'd1,
    K_END    = 4'd2,
    K_NULL   = 4'd3,
    K_BYTE   = 4'd4,
    K_STR    = 4'd5,
    K_PERR   = 4'd6,
    K_XERR   = 4'd7,
    K_TRUNC  = 4'd8,
    K_UNK    = 4'd9,
    K_EMB    = 4'd10,
    K_EMBEND = 4'd11,
    K_OVF    = 4'd12
  } kind_t;

  typedef enum logic [4:0] {
    PH_MSG, PH_CLASS, PH_DELTA, PH_HAND0, PH_HANDN, PH_PROP, PH_PID, PH_FIX,
    PH_EXT, PH_TAG, PH_SLEN, PH_SDATA, PH_ACNT, PH_BDATA, PH_ERRB, PH_DROP
  } phase_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  action;
    logic [9:0]  class_id;
    logic [7:0]  delta_ref;
    logic [30:0] handler_id;
    logic [3:0]  prop_type;
    logic [7:0]  prop_subtype;
    logic [11:0] prop_id;
    logic [63:0] value;
    logic [31:0] elem_count;
    logic [3:0]  nest_depth;
  } token_t;

  // All tokens caused by one input item.
  typedef struct packed {
    logic [1:0]       cnt;
    token_t [2:0]     tok;
  } entry_t;

endpackage

// ===== src/fmt_front.sv =====
// ----------------------------------------------------------------------------
// Tokenizer front end
// Parses one byte per accepted item and builds the tokens it causes.
// ----------------------------------------------------------------------------
module fmt_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  output fmt_pkg::entry_t entry
);
  import fmt_pkg::*;

  phase_t              ph_r, ph_nxt;
  logic [2:0]          fbi_r, fbi_nxt;
  logic [63:0]         asm_r, asm_nxt;
  logic [31:0]         rb_r, rb_nxt;
  logic [31:0]         re_r, re_nxt;
  logic [2:0]          act_r, act_nxt;
  logic [9:0]          cls_r, cls_nxt;
  logic [3:0]          pty_r, pty_nxt;
  logic [7:0]          psb_r, psb_nxt;
  logic [11:0]         pid_r, pid_nxt;
  logic [DEPTH_W-1:0]  dep_r, dep_nxt;
  logic                pend_r, pend_nxt;

  function automatic logic [3:0] sat_depth(input logic [DEPTH_W-1:0] d);
    logic [31:0] w;
    w = 32'(d);
    return (w > 32'd15) ? 4'hf : w[3:0];
  endfunction

  function automatic token_t mk(input kind_t k, input logic prop,
                                input logic [3:0] pt, input logic [7:0] ps,
                                input logic [11:0] pi, input logic [63:0] v,
                                input logic [31:0] c, input logic [DEPTH_W-1:0] d);
    token_t t;
    t = '0;
    t.kind = k;
    if (prop) begin
      t.prop_type = pt;
      t.prop_subtype = ps;
      t.prop_id = pi;
    end
    t.value = v;
    t.elem_count = c;
    t.nest_depth = sat_depth(d);
    return t;
  endfunction

  // Parser step: next state and the tokens of this byte.
  always_comb begin
    token_t     tk [4];
    logic [1:0] n;
    logic       dispatch;
    logic [7:0] b;
    logic [3:0] nib;
    logic [31:0] cnt;
    b = data_byte;
    nib = b[7:4];
    n = 2'd0;
    for (int i = 0; i < 4; i++) tk[i] = '0;
    cnt = '0;
    ph_nxt = ph_r; fbi_nxt = fbi_r; asm_nxt = asm_r; rb_nxt = rb_r; re_nxt = re_r;
    act_nxt = act_r; cls_nxt = cls_r; pty_nxt = pty_r; psb_nxt = psb_r;
    pid_nxt = pid_r; dep_nxt = dep_r; pend_nxt = pend_r;
    dispatch = 1'b1;

    // Pending marker byte from message start.
    if (pend_r) begin
      pend_nxt = 1'b0;
      if (last_byte) begin
        tk[n] = mk(K_END, 1'b0, pty_nxt, psb_nxt, pid_nxt, 64'(b), '0, dep_nxt);
        n = n + 2'd1;
        dispatch = 1'b0;
      end else begin
        tk[n] = mk(K_NULL, 1'b0, pty_nxt, psb_nxt, pid_nxt, 64'(MARK_BYTE), '0, dep_nxt);
        n = n + 2'd1;
        if (dep_nxt != '0) begin
          dep_nxt = dep_nxt - 1'b1;
          tk[n] = mk(K_EMBEND, 1'b0, pty_nxt, psb_nxt, pid_nxt, 64'(MARK_BYTE), '0,
                     dep_nxt);
          n = n + 2'd1;
          ph_nxt = PH_PROP;
        end else begin
          ph_nxt = PH_MSG;
        end
      end
    end

    if (dispatch) begin
      case (ph_nxt)
        PH_MSG: begin
          if (b == MARK_BYTE) begin
            if (last_byte) begin
              tk[n] = mk(K_NULL, 1'b0, pty_nxt, psb_nxt, pid_nxt, 64'(MARK_BYTE), '0,
                         dep_nxt);
              n = n + 2'd1;
            end else begin
              pend_nxt = 1'b1;
            end
          end else if (nib[3]) begin
            tk[n] = mk(K_UNK, 1'b0, pty_nxt, psb_nxt, pid_nxt, 64'(b), '0, dep_nxt);
            n = n + 2'd1;
            ph_nxt = PH_DROP;
          end else begin
            act_nxt = nib[2:0];
            cls_nxt = {b[1:0], 8'h00};
            asm_nxt = '0;
            if (nib == 4'd0 || nib == 4'd4) ph_nxt = PH_CLASS;
            else if (nib == 4'd5) ph_nxt = PH_DELTA;
            else ph_nxt = PH_HAND0;
          end
        end
        PH_CLASS: begin
          cls_nxt = {cls_nxt[9:8], b};
          ph_nxt = (act_nxt == 3'd4) ? PH_DELTA : PH_HAND0;
        end
        PH_DELTA: begin
          asm_nxt = {24'h0, b, 32'h0};
          ph_nxt = PH_HAND0;
        end
        PH_HAND0: begin
          if (b[7]) begin
            asm_nxt = {24'h0, asm_nxt[39:32], 25'h0, b[6:0]};
            fbi_nxt = 3'd2;
          end else begin
            asm_nxt = {24'h0, asm_nxt[39:32], 24'h0, b};
            fbi_nxt = 3'd0;
          end
          ph_nxt = PH_HANDN;
        end
        PH_HANDN: begin
          asm_nxt = {24'h0, asm_nxt[39:32], 1'b0, asm_nxt[22:0], b};
          if (fbi_nxt == 3'd0) begin
            tk[n] = mk(K_HDR, 1'b0, pty_nxt, psb_nxt, pid_nxt, '0, '0, dep_nxt);
            tk[n].action = act_nxt;
            tk[n].class_id = cls_nxt;
            tk[n].delta_ref = asm_nxt[39:32];
            tk[n].handler_id = asm_nxt[30:0];
            n = n + 2'd1;
            ph_nxt = PH_PROP;
          end else begin
            fbi_nxt = fbi_nxt - 3'd1;
          end
        end
        PH_PROP: begin
          if (b == MARK_BYTE) begin
            if (dep_nxt != '0) begin
              dep_nxt = dep_nxt - 1'b1;
              tk[n] = mk(K_EMBEND, 1'b0, pty_nxt, psb_nxt, pid_nxt, 64'(MARK_BYTE), '0,
                         dep_nxt);
              n = n + 2'd1;
              ph_nxt = PH_PROP;
            end else begin
              ph_nxt = PH_MSG;
            end
          end else begin
            pty_nxt = nib;
            psb_nxt = '0;
            pid_nxt = '0;
            if (nib == 4'hb) begin
              tk[n] = mk(K_PROP, 1'b1, pty_nxt, psb_nxt, pid_nxt, 64'(b[3:0]), '0, dep_nxt);
              n = n + 2'd1;
              ph_nxt = PH_PROP;
            end else if (nib == 4'hd) begin
              asm_nxt = '0; fbi_nxt = 3'd1; ph_nxt = PH_FIX;
            end else begin
              pid_nxt = {b[3:0], 8'h00};
              ph_nxt = PH_PID;
            end
          end
        end
        PH_PID: begin
          pid_nxt = {pid_nxt[11:8], b};
          ph_nxt = PH_PROP;
          case (pty_nxt)
            4'h0, 4'ha: begin asm_nxt = '0; fbi_nxt = 3'd3; ph_nxt = PH_FIX; end
            4'h2, 4'h7: begin asm_nxt = '0; fbi_nxt = 3'd0; ph_nxt = PH_FIX; end
            4'h3, 4'h9, 4'hc: begin asm_nxt = '0; fbi_nxt = 3'd1; ph_nxt = PH_FIX; end
            4'h4: ph_nxt = PH_TAG;
            4'h5: begin
              tk[n] = mk(K_PROP, 1'b1, pty_nxt, psb_nxt, pid_nxt, 64'd1, '0, dep_nxt);
              n = n + 2'd1;
            end
            4'he: ph_nxt = PH_EXT;
            4'hf: ph_nxt = PH_ERRB;
            default: begin
              tk[n] = mk(K_PROP, 1'b1, pty_nxt, psb_nxt, pid_nxt, 64'd0, '0, dep_nxt);
              n = n + 2'd1;
            end
          endcase
        end
        PH_FIX: begin
          asm_nxt = {asm_nxt[55:0], b};
          if (fbi_nxt == 3'd0) begin
            tk[n] = mk(K_PROP, 1'b1, pty_nxt, psb_nxt, pid_nxt, asm_nxt, '0, dep_nxt);
            n = n + 2'd1;
            ph_nxt = PH_PROP;
          end else begin
            fbi_nxt = fbi_nxt - 3'd1;
          end
        end
        PH_EXT: begin
          psb_nxt = b;
          ph_nxt = PH_PROP;
          case (b)
            8'd2, 8'd7, 8'd15: begin asm_nxt = '0; fbi_nxt = 3'd3; ph_nxt = PH_ACNT; end
            8'd4: begin asm_nxt = '0; fbi_nxt = 3'd0; ph_nxt = PH_FIX; end
            8'd5: begin asm_nxt = '0; fbi_nxt = 3'd3; ph_nxt = PH_FIX; end
            8'd6, 8'd10: begin asm_nxt = '0; fbi_nxt = 3'd7; ph_nxt = PH_FIX; end
            8'd8: begin
              if (dep_nxt >= DEPTH_W'(MAX_NEST_DEPTH)) begin
                tk[n] = mk(K_OVF, 1'b1, pty_nxt, psb_nxt, pid_nxt, '0, '0, dep_nxt);
                n = n + 2'd1;
                ph_nxt = PH_DROP;
              end else begin
                tk[n] = mk(K_EMB, 1'b1, pty_nxt, psb_nxt, pid_nxt, '0, '0, dep_nxt);
                n = n + 2'd1;
                dep_nxt = dep_nxt + 1'b1;
                ph_nxt = PH_MSG;
              end
            end
            default: begin
              tk[n] = mk(K_XERR, 1'b1, pty_nxt, psb_nxt, pid_nxt, 64'(b), '0, dep_nxt);
              n = n + 2'd1;
            end
          endcase
        end
        PH_TAG: begin
          tk[n] = mk(K_PROP, 1'b1, pty_nxt, psb_nxt, pid_nxt, 64'(b), '0, dep_nxt);
          n = n + 2'd1;
          re_nxt = 32'd1;
          asm_nxt = '0; fbi_nxt = 3'd1; ph_nxt = PH_SLEN;
        end
        PH_SLEN: begin
          asm_nxt = {asm_nxt[55:0], b};
          if (fbi_nxt == 3'd0) begin
            cnt = {16'h0, asm_nxt[15:0]};
            if (re_nxt != '0) re_nxt = re_nxt - 32'd1;
            tk[n] = mk(K_STR, 1'b1, pty_nxt, psb_nxt, pid_nxt, '0, cnt, dep_nxt);
            n = n + 2'd1;
            rb_nxt = cnt;
            if (cnt == '0) begin
              if (re_nxt != '0) begin
                asm_nxt = '0; fbi_nxt = 3'd1; ph_nxt = PH_SLEN;
              end else begin
                ph_nxt = PH_PROP;
              end
            end else begin
              ph_nxt = PH_SDATA;
            end
          end else begin
            fbi_nxt = fbi_nxt - 3'd1;
          end
        end
        PH_SDATA: begin
          tk[n] = mk(K_BYTE, 1'b1, pty_nxt, psb_nxt, pid_nxt, 64'(b), '0, dep_nxt);
          n = n + 2'd1;
          if (rb_nxt != '0) rb_nxt = rb_nxt - 32'd1;
          if (rb_nxt == '0) begin
            if (re_nxt != '0) begin
              asm_nxt = '0; fbi_nxt = 3'd1; ph_nxt = PH_SLEN;
            end else begin
              ph_nxt = PH_PROP;
            end
          end
        end
        PH_ACNT: begin
          asm_nxt = {asm_nxt[55:0], b};
          if (fbi_nxt == 3'd0) begin
            cnt = asm_nxt[31:0];
            tk[n] = mk(K_PROP, 1'b1, pty_nxt, psb_nxt, pid_nxt, '0, cnt, dep_nxt);
            n = n + 2'd1;
            if (psb_nxt == 8'd2) begin
              re_nxt = cnt;
              if (cnt != '0) begin
                asm_nxt = '0; fbi_nxt = 3'd1; ph_nxt = PH_SLEN;
              end else begin
                ph_nxt = PH_PROP;
              end
            end else begin
              rb_nxt = cnt;
              ph_nxt = (cnt != '0) ? PH_BDATA : PH_PROP;
            end
          end else begin
            fbi_nxt = fbi_nxt - 3'd1;
          end
        end
        PH_BDATA: begin
          tk[n] = mk(K_BYTE, 1'b1, pty_nxt, psb_nxt, pid_nxt, 64'(b), '0, dep_nxt);
          n = n + 2'd1;
          if (rb_nxt != '0) rb_nxt = rb_nxt - 32'd1;
          if (rb_nxt == '0) ph_nxt = PH_PROP;
        end
        PH_ERRB: begin
          tk[n] = mk(K_PERR, 1'b1, pty_nxt, psb_nxt, pid_nxt, 64'(b), '0, dep_nxt);
          n = n + 2'd1;
          ph_nxt = PH_PROP;
        end
        default: begin
        end
      endcase
    end

    // Buffer end: flag an unfinished field, then return to reset state.
    if (last_byte) begin
      if (ph_nxt != PH_MSG && ph_nxt != PH_PROP && ph_nxt != PH_DROP) begin
        tk[n] = mk(K_TRUNC, 1'b0, pty_nxt, psb_nxt, pid_nxt, '0, '0, dep_nxt);
        n = n + 2'd1;
      end
      ph_nxt = PH_MSG; fbi_nxt = '0; asm_nxt = '0; rb_nxt = '0; re_nxt = '0;
      act_nxt = '0; cls_nxt = '0; pty_nxt = '0; psb_nxt = '0; pid_nxt = '0;
      dep_nxt = '0; pend_nxt = 1'b0;
    end

    entry.cnt = n;
    entry.tok[0] = tk[0];
    entry.tok[1] = tk[1];
    entry.tok[2] = tk[2];
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_MSG; fbi_r <= '0; asm_r <= '0; rb_r <= '0; re_r <= '0;
      act_r <= '0; cls_r <= '0; pty_r <= '0; psb_r <= '0; pid_r <= '0;
      dep_r <= '0; pend_r <= 1'b0;
    end else if (accept) begin
      ph_r <= ph_nxt; fbi_r <= fbi_nxt; asm_r <= asm_nxt; rb_r <= rb_nxt;
      re_r <= re_nxt; act_r <= act_nxt; cls_r <= cls_nxt; pty_r <= pty_nxt;
      psb_r <= psb_nxt; pid_r <= pid_nxt; dep_r <= dep_nxt; pend_r <= pend_nxt;
    end
  end

endmodule

// ===== src/fmt_queue.sv =====
// ----------------------------------------------------------------------------
// Tokenizer queue
// Small register queue of token groups between the parser and the output.
// ----------------------------------------------------------------------------
module fmt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fmt_pkg::entry_t push_entry,
  input  logic            pop,
  output fmt_pkg::entry_t head,
  output logic            empty,
  output logic            full
);
  import fmt_pkg::*;

  entry_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, rp_r;
  logic [QCNT_W-1:0]   cnt_r;

  assign head  = mem_r[rp_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCNT_W'(QDEPTH));

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_entry;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop) rp_r <= (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

// ===== src/fmt_back.sv =====
// ----------------------------------------------------------------------------
// Tokenizer back end
// Hands the queued tokens out one per item through an output register.
// ----------------------------------------------------------------------------
module fmt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  fmt_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  input  logic            out_ready,
  output logic            out_valid,
  output fmt_pkg::token_t out_tok,
  output logic            out_last
);
  import fmt_pkg::*;

  logic [1:0] idx_r;
  logic       vld_r;
  token_t     tok_r;
  logic       last_r;
  logic       load;
  logic       at_end;
  token_t     sel;

  assign load   = !empty && (!vld_r || out_ready);
  assign at_end = (idx_r == head.cnt - 2'd1);
  assign pop    = load && at_end;

  // Pick the token at the current place in the head group.
  always_comb begin
    case (idx_r)
      2'd1: sel = head.tok[1];
      2'd2: sel = head.tok[2];
      default: sel = head.tok[0];
    endcase
  end

  // Output register and group position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
        idx_r <= at_end ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r <= sel;
      last_r <= at_end;
    end
  end

  assign out_valid = vld_r;
  assign out_tok   = tok_r;
  assign out_last  = last_r;

endmodule

// ===== src/forms_message_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// Forms message tokenizer
// Turns a forms-protocol byte stream into header, property and content tokens.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while its four-entry token queue has room,
// and gives one token per cycle while out_ready is high; a byte yields zero to
// three tokens, so a run of bytes that each cause several tokens is limited by
// the single output register and fills the queue until in_ready drops. A byte
// that yields no token is finished the cycle it is accepted; a byte's first
// token is written into the queue when the byte is accepted and then loaded
// into the output register, from which it is taken while out_ready is high.
module forms_message_tokenizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_token_kind,
  output logic [2:0]  out_action,
  output logic [9:0]  out_class_id,
  output logic [7:0]  out_delta_ref,
  output logic [30:0] out_handler_id,
  output logic [3:0]  out_prop_type,
  output logic [7:0]  out_prop_subtype,
  output logic [11:0] out_prop_id,
  output logic [63:0] out_value,
  output logic [31:0] out_elem_count,
  output logic [3:0]  out_nest_depth,
  output logic        out_last_of_run
);
  import fmt_pkg::*;

  entry_t  new_entry, head;
  logic    accept, push, pop, empty, full;
  token_t  tok;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (new_entry.cnt != 2'd0);

  fmt_front u_front (
    .clk, .rst_n, .accept,
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .entry     (new_entry)
  );

  fmt_queue u_queue (
    .clk, .rst_n, .push,
    .push_entry (new_entry),
    .pop, .head, .empty, .full
  );

  fmt_back u_back (
    .clk, .rst_n, .head, .empty, .pop, .out_ready, .out_valid,
    .out_tok  (tok),
    .out_last (out_last_of_run)
  );

  assign out_token_kind   = tok.kind;
  assign out_action       = tok.action;
  assign out_class_id     = tok.class_id;
  assign out_delta_ref    = tok.delta_ref;
  assign out_handler_id   = tok.handler_id;
  assign out_prop_type    = tok.prop_type;
  assign out_prop_subtype = tok.prop_subtype;
  assign out_prop_id      = tok.prop_id;
  assign out_value        = tok.value;
  assign out_elem_count   = tok.elem_count;
  assign out_nest_depth   = tok.nest_depth;

  // The queue is never written when full nor read when empty.
  assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("token queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("token queue underflow");

  // A queued group always holds at least one token.
  assert property (@(posedge clk) disable iff (!rst_n) !empty |-> head.cnt != 2'd0)
    else $error("empty token group queued");

  // Reported depth never passes the nesting limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_nest_depth) <= MAX_NEST_DEPTH)
    else $error("nest depth beyond limit");

endmodule
